### hw/rtl/psc_pkg.sv
// Shared types and constants of the pretrigger snapshot capture block.
// Used by the channel interfaces, the controller, the datapath and the output buffer.
// Depends on nothing.
package psc_pkg;

	localparam int OPC_W       = 3;
	localparam int SMP_W       = 16;
	localparam int BACK_W      = 8;
	localparam int LEN_W       = 7;
	localparam int STAT_W      = 4;
	localparam int CNT_W       = 32;
	localparam int THR_W       = 15;
	localparam int MAX_RESULTS = 32;

	localparam logic [THR_W-1:0] THR_RESET = 15'd2000;

	// Opcodes of an input transaction.
	localparam logic [OPC_W-1:0] OP_SAMPLE   = 3'd0;
	localparam logic [OPC_W-1:0] OP_SERVICE  = 3'd1;
	localparam logic [OPC_W-1:0] OP_HISTORY  = 3'd2;
	localparam logic [OPC_W-1:0] OP_SNAPSHOT = 3'd3;
	localparam logic [OPC_W-1:0] OP_CLEAR    = 3'd4;

	// Status codes of an output transaction.
	localparam logic [STAT_W-1:0] ST_STORED    = 4'd0;
	localparam logic [STAT_W-1:0] ST_TRIGGER   = 4'd1;
	localparam logic [STAT_W-1:0] ST_SVC_IDLE  = 4'd2;
	localparam logic [STAT_W-1:0] ST_CAPTURED  = 4'd3;
	localparam logic [STAT_W-1:0] ST_HISTORY   = 4'd4;
	localparam logic [STAT_W-1:0] ST_SNAP_WORD = 4'd5;
	localparam logic [STAT_W-1:0] ST_REFUSED   = 4'd6;
	localparam logic [STAT_W-1:0] ST_EMPTY     = 4'd7;
	localparam logic [STAT_W-1:0] ST_CLEARED   = 4'd8;

	typedef enum logic [2:0] {
		S_IDLE,
		S_COPY,
		S_CFIN,
		S_HMOD,
		S_HOUT,
		S_DRD,
		S_DOUT
	} state_t;

	typedef enum logic [1:0] {
		DSEL_ZERO,
		DSEL_HIST,
		DSEL_SNAP
	} dsel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic               do_sample;
		logic               do_clear;
		logic               svc_start;
		logic               copy_rd;
		logic               commit_snap;
		logic               hist_load;
		logic               rem_sub;
		logic               hist_rd;
		logic               snap_take;
		logic               drain_rd;
		logic               cnt_inc;
		logic               push;
		logic               last;
		logic [STAT_W-1:0]  code;
		dsel_t              dsel;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic trig;
		logic pending;
		logic snap_full;
		logic len_ok;
		logic len_zero;
		logic rem_ge;
		logic copy_last;
		logic drain_last;
	} stat_t;

	typedef struct packed {
		logic [STAT_W-1:0]       status;
		logic signed [SMP_W-1:0] data_value;
		logic                    last;
		logic [CNT_W-1:0]        trigger_total;
		logic [CNT_W-1:0]        snapshot_total;
	} res_t;

endpackage

### hw/rtl/psc_in_if.sv
// Input channel of the pretrigger snapshot capture block: valid, ready and one command item.
// Depends on psc_pkg.
interface psc_in_if import psc_pkg::*; ();

	logic                    valid;
	logic                    ready;
	logic [OPC_W-1:0]        opcode;
	logic signed [SMP_W-1:0] sample_value;
	logic [BACK_W-1:0]       back_distance;
	logic [LEN_W-1:0]        snapshot_length;

	modport source (
		output valid, opcode, sample_value, back_distance, snapshot_length,
		input  ready
	);

	modport sink (
		input  valid, opcode, sample_value, back_distance, snapshot_length,
		output ready
	);

endinterface

### hw/rtl/psc_out_if.sv
// Output channel of the pretrigger snapshot capture block: valid, ready and one result item.
// Depends on psc_pkg.
interface psc_out_if import psc_pkg::*; ();

	logic                    valid;
	logic                    ready;
	logic [STAT_W-1:0]       status;
	logic signed [SMP_W-1:0] data_value;
	logic                    last;
	logic [CNT_W-1:0]        trigger_total;
	logic [CNT_W-1:0]        snapshot_total;

	modport source (
		output valid, status, data_value, last, trigger_total, snapshot_total,
		input  ready
	);

	modport sink (
		input  valid, status, data_value, last, trigger_total, snapshot_total,
		output ready
	);

endinterface

### hw/rtl/pretrigger_snapshot_capture.sv
// Pretrigger snapshot capture: signed ADC samples go into a history ring; a threshold hit in a
// block of samples latches a capture that a service transaction copies into a snapshot store.
//
// Channels: in_ch carries one command transaction (opcode, sample, read distance, drain length);
// out_ch returns result transactions (status, data word, last, trigger and snapshot totals).
// cfg_wr_en / cfg_wr_data write the 15-bit trigger threshold; write it only while idle.
//
// Throughput: a sample, a service on an idle block, a refused or zero-length drain and a clear
// each finish in the idle state, so samples stream at one per cycle while out_ch keeps up.
// A history read takes HIST_DEPTH off back_distance, one subtract per cycle in the datapath,
// while the rest is at least HIST_DEPTH, then reads the ring. A service that captures copies
// SNAP_DEPTH words, one word per cycle through the single read port of the history ring.
// A drain returns each word only after the registered read of the snapshot store.
// Each result is registered in the output buffer before it appears on out_ch.
//
// Reset clears the ring's fill tracking, so the ring reads as all zero without a sweep; the
// threshold returns to 2000. The block is ready right after reset.
// Stalls: the output register plus a skid stage let one transaction complete while a result
// waits; once both hold data, in_ch.ready drops and no further result is pushed until out_ch drains.
module pretrigger_snapshot_capture import psc_pkg::*; #(
	parameter int HIST_DEPTH = 256,
	parameter int SNAP_DEPTH = 32,
	parameter int BLOCK_SIZE = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [THR_W-1:0] cfg_wr_data,
	psc_in_if.sink           in_ch,
	psc_out_if.source        out_ch
);

	cmd_t  cmd;
	stat_t stat;
	res_t  res;
	res_t  res_out;
	logic  can_push;

	// The controller sequences each opcode; the datapath owns all storage and arithmetic.
	psc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_opcode (in_ch.opcode),
		.stat      (stat),
		.can_push  (can_push),
		.in_ready  (in_ch.ready),
		.cmd       (cmd)
	);

	psc_datapath #(
		.HIST_DEPTH (HIST_DEPTH),
		.SNAP_DEPTH (SNAP_DEPTH),
		.BLOCK_SIZE (BLOCK_SIZE)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_sample   (in_ch.sample_value),
		.in_back     (in_ch.back_distance),
		.in_len      (in_ch.snapshot_length),
		.cmd         (cmd),
		.stat        (stat),
		.res         (res)
	);

	// Every result passes through the output register, and through the skid stage while that is held.
	psc_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd.push),
		.din       (res),
		.can_push  (can_push),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.dout      (res_out)
	);

	assign out_ch.status         = res_out.status;
	assign out_ch.data_value     = res_out.data_value;
	assign out_ch.last           = res_out.last;
	assign out_ch.trigger_total  = res_out.trigger_total;
	assign out_ch.snapshot_total = res_out.snapshot_total;

endmodule

### hw/rtl/psc_ctrl.sv
// Controller state machine of the pretrigger snapshot capture block.
// Depends on psc_pkg; drives the datapath through cmd_t and reads back stat_t.
module psc_ctrl import psc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [OPC_W-1:0] in_opcode,
	input  stat_t            stat,
	input  logic             can_push,
	output logic             in_ready,
	output cmd_t             cmd
);

	state_t state_q;
	state_t state_d;
	logic   take;

	assign take = in_valid && can_push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (take) begin
					unique case (in_opcode)
						OP_SERVICE: begin
							if (stat.pending && !stat.snap_full) state_d = S_COPY;
						end
						OP_HISTORY: state_d = S_HMOD;
						OP_SNAPSHOT: begin
							if (stat.snap_full && stat.len_ok && !stat.len_zero) state_d = S_DRD;
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_COPY: begin
				if (stat.copy_last) state_d = S_CFIN;
			end
			S_CFIN: begin
				if (can_push) state_d = S_IDLE;
			end
			S_HMOD: begin
				if (!stat.rem_ge) state_d = S_HOUT;
			end
			S_HOUT: begin
				if (can_push) state_d = S_IDLE;
			end
			S_DRD: state_d = S_DOUT;
			S_DOUT: begin
				if (can_push) state_d = stat.drain_last ? S_IDLE : S_DRD;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.last = 1'b1;
		cmd.code = ST_REFUSED;
		cmd.dsel = DSEL_ZERO;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = can_push;
				if (take) begin
					unique case (in_opcode)
						OP_SAMPLE: begin
							cmd.do_sample = 1'b1;
							cmd.push      = 1'b1;
							cmd.code      = stat.trig ? ST_TRIGGER : ST_STORED;
						end
						OP_SERVICE: begin
							if (stat.pending && !stat.snap_full) begin
								cmd.svc_start = 1'b1;
							end else begin
								cmd.push = 1'b1;
								cmd.code = ST_SVC_IDLE;
							end
						end
						OP_HISTORY: cmd.hist_load = 1'b1;
						OP_SNAPSHOT: begin
							if (stat.snap_full && stat.len_ok) begin
								cmd.snap_take = 1'b1;
								if (stat.len_zero) begin
									cmd.push = 1'b1;
									cmd.code = ST_EMPTY;
								end
							end else begin
								cmd.push = 1'b1;
								cmd.code = ST_REFUSED;
							end
						end
						OP_CLEAR: begin
							cmd.do_clear = 1'b1;
							cmd.push     = 1'b1;
							cmd.code     = ST_CLEARED;
						end
						default: begin
							cmd.push = 1'b1;
							cmd.code = ST_REFUSED;
						end
					endcase
				end
			end
			S_COPY: begin
				cmd.copy_rd = 1'b1;
				cmd.cnt_inc = 1'b1;
			end
			S_CFIN: begin
				if (can_push) begin
					cmd.commit_snap = 1'b1;
					cmd.push        = 1'b1;
					cmd.code        = ST_CAPTURED;
				end
			end
			S_HMOD: begin
				if (stat.rem_ge) begin
					cmd.rem_sub = 1'b1;
				end else begin
					cmd.hist_rd = 1'b1;
				end
			end
			S_HOUT: begin
				cmd.push = can_push;
				cmd.code = ST_HISTORY;
				cmd.dsel = DSEL_HIST;
			end
			S_DRD: cmd.drain_rd = 1'b1;
			S_DOUT: begin
				cmd.code = ST_SNAP_WORD;
				cmd.dsel = DSEL_SNAP;
				cmd.last = stat.drain_last;
				if (can_push) begin
					cmd.push    = 1'b1;
					cmd.cnt_inc = !stat.drain_last;
				end
			end
			default: cmd = '0;
		endcase
	end

endmodule

### hw/rtl/psc_datapath.sv
// Datapath of the pretrigger snapshot capture block: history ring, snapshot store,
// trigger detection, counters and result assembly. Depends on psc_pkg.
module psc_datapath import psc_pkg::*; #(
	parameter int HIST_DEPTH = 256,
	parameter int SNAP_DEPTH = 32,
	parameter int BLOCK_SIZE = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wr_en,
	input  logic [THR_W-1:0]        cfg_wr_data,
	input  logic signed [SMP_W-1:0] in_sample,
	input  logic [BACK_W-1:0]       in_back,
	input  logic [LEN_W-1:0]        in_len,
	input  cmd_t                    cmd,
	output stat_t                   stat,
	output res_t                    res
);

	localparam int AW       = $clog2(HIST_DEPTH);
	localparam int AW1      = AW + 1;
	localparam int SW       = (SNAP_DEPTH > 1) ? $clog2(SNAP_DEPTH) : 1;
	localparam int BPW      = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;
	localparam int SNAP_MOD = SNAP_DEPTH % HIST_DEPTH;
	localparam int CW       = AW + BACK_W + 1;

	logic [THR_W-1:0]  thr_q;
	logic [AW-1:0]     wp_q;
	logic              filled_q;
	logic [BPW-1:0]    bp_q;
	logic              block_hit_q;
	logic              pending_q;
	logic [AW-1:0]     anchor_q;
	logic              ready_q;
	logic [CNT_W-1:0]  trig_cnt_q;
	logic [CNT_W-1:0]  snap_cnt_q;
	logic [BACK_W-1:0] rem_q;
	logic [AW-1:0]     copy_addr_q;
	logic [SW-1:0]     idx_q;
	logic [LEN_W-1:0]  len_q;

	logic signed [SMP_W-1:0] ring_mem [HIST_DEPTH];
	logic signed [SMP_W-1:0] snap_mem [SNAP_DEPTH];
	logic signed [SMP_W-1:0] ring_rd_s1;
	logic                    ring_ok_s1;
	logic                    cp_wr_s1;
	logic [SW-1:0]           cp_idx_s1;
	logic signed [SMP_W-1:0] snap_rd_s1;

	logic signed [SMP_W:0] smp_ext;
	logic signed [SMP_W:0] thr_ext;
	logic                  hit;
	logic                  hit_any;
	logic                  blk_end;
	logic                  trig;
	logic                  wp_wrap;
	logic [AW-1:0]         wp_next;
	logic [AW1-1:0]        rem_ext;
	logic [AW1-1:0]        wp_ext;
	logic [AW1-1:0]        hist_idx_w;
	logic [AW1-1:0]        anc_ext;
	logic [AW1-1:0]        start_w;
	logic [AW-1:0]         copy_next;
	logic [AW-1:0]         rd_addr;
	logic                  rd_ok;
	logic [CNT_W-1:0]      trig_cnt_d;
	logic [CNT_W-1:0]      snap_cnt_d;
	logic signed [SMP_W-1:0] data_sel;

	// A sample triggers when it lies strictly outside the band of plus or minus the threshold.
	assign smp_ext = {in_sample[SMP_W-1], in_sample};
	assign thr_ext = {2'b00, thr_q};
	assign hit     = (smp_ext > thr_ext) || (smp_ext < -thr_ext);
	assign hit_any = block_hit_q || hit;
	assign blk_end = (bp_q == BPW'(BLOCK_SIZE - 1));
	assign trig    = blk_end && hit_any && !pending_q;

	assign wp_wrap = (wp_q == AW'(HIST_DEPTH - 1));
	assign wp_next = wp_wrap ? '0 : wp_q + 1'b1;

	// History index is the write position minus the reduced distance, wrapped into the ring.
	assign rem_ext    = AW1'(rem_q);
	assign wp_ext     = {1'b0, wp_q};
	assign hist_idx_w = (wp_ext >= rem_ext) ? (wp_ext - rem_ext)
	                                        : (wp_ext + AW1'(HIST_DEPTH) - rem_ext);

	assign anc_ext = {1'b0, anchor_q};
	assign start_w = (anc_ext >= AW1'(SNAP_MOD)) ? (anc_ext - AW1'(SNAP_MOD))
	                                             : (anc_ext + AW1'(HIST_DEPTH - SNAP_MOD));
	assign copy_next = (copy_addr_q == AW'(HIST_DEPTH - 1)) ? '0 : copy_addr_q + 1'b1;

	// Entries are written in order from zero after a clear, so an entry holds data once the
	// ring has wrapped or when it lies below the write position; otherwise it reads as zero.
	assign rd_addr = cmd.copy_rd ? copy_addr_q : hist_idx_w[AW-1:0];
	assign rd_ok   = filled_q || (rd_addr < wp_q);

	always_comb begin
		trig_cnt_d = trig_cnt_q;
		snap_cnt_d = snap_cnt_q;
		if (cmd.do_clear) begin
			trig_cnt_d = '0;
			snap_cnt_d = '0;
		end else begin
			if (cmd.do_sample && trig) trig_cnt_d = trig_cnt_q + 1'b1;
			if (cmd.commit_snap) snap_cnt_d = snap_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= THR_RESET;
			wp_q        <= '0;
			filled_q    <= 1'b0;
			bp_q        <= '0;
			block_hit_q <= 1'b0;
			pending_q   <= 1'b0;
			anchor_q    <= '0;
			ready_q     <= 1'b0;
			trig_cnt_q  <= '0;
			snap_cnt_q  <= '0;
			rem_q       <= '0;
			copy_addr_q <= '0;
			idx_q       <= '0;
			len_q       <= '0;
			cp_wr_s1    <= 1'b0;
		end else begin
			if (cfg_wr_en) thr_q <= cfg_wr_data;
			trig_cnt_q <= trig_cnt_d;
			snap_cnt_q <= snap_cnt_d;
			cp_wr_s1   <= cmd.copy_rd;
			if (cmd.do_clear) begin
				wp_q        <= '0;
				filled_q    <= 1'b0;
				bp_q        <= '0;
				block_hit_q <= 1'b0;
				pending_q   <= 1'b0;
				anchor_q    <= '0;
				ready_q     <= 1'b0;
			end
			if (cmd.do_sample) begin
				wp_q <= wp_next;
				if (wp_wrap) filled_q <= 1'b1;
				if (blk_end) begin
					bp_q        <= '0;
					block_hit_q <= 1'b0;
					if (trig) begin
						pending_q <= 1'b1;
						anchor_q  <= wp_next;
					end
				end else begin
					bp_q        <= bp_q + 1'b1;
					block_hit_q <= hit_any;
				end
			end
			if (cmd.svc_start) begin
				copy_addr_q <= start_w[AW-1:0];
				idx_q       <= '0;
			end
			if (cmd.copy_rd) copy_addr_q <= copy_next;
			if (cmd.cnt_inc) idx_q <= idx_q + 1'b1;
			if (cmd.commit_snap) begin
				ready_q   <= 1'b1;
				pending_q <= 1'b0;
			end
			if (cmd.snap_take) begin
				ready_q <= 1'b0;
				len_q   <= in_len;
				idx_q   <= '0;
			end
			if (cmd.hist_load) rem_q <= in_back;
			if (cmd.rem_sub) rem_q <= rem_q - BACK_W'(HIST_DEPTH);
		end
	end

	// History ring: one write port for samples, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.do_sample) ring_mem[wp_q] <= in_sample;
		if (cmd.copy_rd || cmd.hist_rd) begin
			ring_rd_s1 <= ring_mem[rd_addr];
			ring_ok_s1 <= rd_ok;
		end
		if (cmd.copy_rd) cp_idx_s1 <= idx_q;
	end

	// Snapshot store: filled from the ring read stage, drained through a registered read.
	always_ff @(posedge clk) begin
		if (cp_wr_s1) snap_mem[cp_idx_s1] <= ring_ok_s1 ? ring_rd_s1 : '0;
		if (cmd.drain_rd) snap_rd_s1 <= snap_mem[idx_q];
	end

	always_comb begin
		case (cmd.dsel)
			DSEL_HIST: data_sel = ring_ok_s1 ? ring_rd_s1 : '0;
			DSEL_SNAP: data_sel = snap_rd_s1;
			default:   data_sel = '0;
		endcase
	end

	assign stat.trig       = trig;
	assign stat.pending    = pending_q;
	assign stat.snap_full  = ready_q;
	assign stat.len_ok     = ({1'b0, in_len} <= 8'(SNAP_DEPTH)) &&
	                         ({1'b0, in_len} <= 8'(MAX_RESULTS));
	assign stat.len_zero   = (in_len == '0);
	assign stat.rem_ge     = (CW'(rem_q) >= CW'(HIST_DEPTH));
	assign stat.copy_last  = (idx_q == SW'(SNAP_DEPTH - 1));
	assign stat.drain_last = ((8'(idx_q) + 8'd1) == {1'b0, len_q});

	assign res.status         = cmd.code;
	assign res.data_value     = data_sel;
	assign res.last           = cmd.last;
	assign res.trigger_total  = trig_cnt_d;
	assign res.snapshot_total = snap_cnt_d;

endmodule

### hw/rtl/psc_out_buf.sv
// Output register with a skid stage for the pretrigger snapshot capture block.
// Depends on psc_pkg for the result type.
module psc_out_buf import psc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t din,
	output logic can_push,
	output logic out_valid,
	input  logic out_ready,
	output res_t dout
);

	logic out_valid_q;
	logic skid_valid_q;
	res_t out_q;
	res_t skid_q;
	logic slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign can_push  = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign dout      = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (slot_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= push;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
				if (push) skid_q <= din;
			end else if (push) begin
				out_q <= din;
			end
		end else if (push) begin
			skid_q <= din;
		end
	end

endmodule

### tb/psc_scoreboard_pkg.sv
`timescale 1ns / 1ps
// Scoreboard of the pretrigger snapshot capture testbench: its own copy of the block's state
// and a queue of expected results. Depends on psc_pkg.
package psc_tb_pkg;
	import psc_pkg::*;

	localparam int HIST_DEPTH  = 256;
	localparam int SNAP_DEPTH  = 32;
	localparam int BLOCK_SIZE  = 8;
	localparam int MAX_PRINTED = 200;

	// Opcodes with no function in the block; they must be refused.
	localparam logic [OPC_W-1:0] OP_UNKNOWN_LO = 3'd5;
	localparam logic [OPC_W-1:0] OP_UNKNOWN_HI = 3'd7;

	class capture_scoreboard;
		logic [THR_W-1:0]        threshold;
		logic signed [SMP_W-1:0] ring [HIST_DEPTH];
		logic signed [SMP_W-1:0] snap_store [SNAP_DEPTH];
		int                      wr_pos;
		int                      blk_pos;
		bit                      blk_hit;
		bit                      capture_pending;
		int                      anchor;
		bit                      snap_full;
		logic [CNT_W-1:0]        trig_cnt;
		logic [CNT_W-1:0]        snap_cnt;
		res_t                    expected_q[$];
		int                      error_count;

		function new();
			threshold   = THR_RESET;
			error_count = 0;
			clear_state();
		endfunction

		function void clear_state();
			foreach (ring[i]) ring[i] = '0;
			foreach (snap_store[i]) snap_store[i] = '0;
			wr_pos          = 0;
			blk_pos         = 0;
			blk_hit         = 1'b0;
			capture_pending = 1'b0;
			anchor          = 0;
			snap_full       = 1'b0;
			trig_cnt        = '0;
			snap_cnt        = '0;
		endfunction

		function int pending_count();
			return expected_q.size();
		endfunction

		// Counters in a result are the values after the transaction has acted.
		function void push_result(logic [STAT_W-1:0] code, logic signed [SMP_W-1:0] word,
				logic fin);
			res_t r;
			r.status         = code;
			r.data_value     = word;
			r.last           = fin;
			r.trigger_total  = trig_cnt;
			r.snapshot_total = snap_cnt;
			expected_q.push_back(r);
		endfunction

		// Called once per accepted input transaction.
		function void note_input(logic [OPC_W-1:0] op, logic signed [SMP_W-1:0] smp,
				logic [BACK_W-1:0] back, logic [LEN_W-1:0] len);
			int               s;
			int               t;
			int               base;
			logic [STAT_W-1:0] code;
			s = int'(smp);
			t = int'(threshold);
			case (op)
			OP_SAMPLE: begin
				code         = ST_STORED;
				ring[wr_pos] = smp;
				wr_pos       = (wr_pos + 1) % HIST_DEPTH;
				if (s > t || s < -t)
					blk_hit = 1'b1;
				blk_pos++;
				if (blk_pos >= BLOCK_SIZE) begin
					// A hit while a capture waits for service is dropped.
					if (blk_hit && !capture_pending) begin
						capture_pending = 1'b1;
						anchor          = wr_pos;
						trig_cnt++;
						code            = ST_TRIGGER;
					end
					blk_pos = 0;
					blk_hit = 1'b0;
				end
				push_result(code, '0, 1'b1);
			end
			OP_SERVICE: begin
				if (capture_pending && !snap_full) begin
					base = (anchor + HIST_DEPTH - (SNAP_DEPTH % HIST_DEPTH)) % HIST_DEPTH;
					for (int i = 0; i < SNAP_DEPTH; i++)
						snap_store[i] = ring[(base + i) % HIST_DEPTH];
					snap_full       = 1'b1;
					capture_pending = 1'b0;
					snap_cnt++;
					push_result(ST_CAPTURED, '0, 1'b1);
				end else begin
					push_result(ST_SVC_IDLE, '0, 1'b1);
				end
			end
			OP_HISTORY: begin
				base = (wr_pos + HIST_DEPTH - (int'(back) % HIST_DEPTH)) % HIST_DEPTH;
				push_result(ST_HISTORY, ring[base], 1'b1);
			end
			OP_SNAPSHOT: begin
				if (!snap_full || len > SNAP_DEPTH || len > MAX_RESULTS) begin
					push_result(ST_REFUSED, '0, 1'b1);
				end else begin
					snap_full = 1'b0;
					if (len == 0)
						push_result(ST_EMPTY, '0, 1'b1);
					else
						for (int i = 0; i < len; i++)
							push_result(ST_SNAP_WORD, snap_store[i], i == len - 1);
				end
			end
			OP_CLEAR: begin
				clear_state();
				push_result(ST_CLEARED, '0, 1'b1);
			end
			default: begin
				push_result(ST_REFUSED, '0, 1'b1);
			end
			endcase
		endfunction

		task report(string msg);
			error_count++;
			if (error_count <= MAX_PRINTED)
				$display("%0t ns: mismatch: %s", $time, msg);
		endtask

		// Called once per accepted output transaction; compares with the oldest expectation.
		task check_result(res_t got);
			res_t  want;
			string diffs;
			if (expected_q.size() == 0) begin
				report($sformatf("result with nothing expected: status %0d data %0d",
					got.status, got.data_value));
				return;
			end
			want  = expected_q.pop_front();
			diffs = "";
			if (got.status !== want.status)
				diffs = {diffs, $sformatf(" status %0d/%0d", got.status, want.status)};
			if (got.data_value !== want.data_value)
				diffs = {diffs, $sformatf(" data %0d/%0d", got.data_value, want.data_value)};
			if (got.last !== want.last)
				diffs = {diffs, $sformatf(" last %0d/%0d", got.last, want.last)};
			if (got.trigger_total !== want.trigger_total)
				diffs = {diffs, $sformatf(" triggers %0d/%0d", got.trigger_total,
					want.trigger_total)};
			if (got.snapshot_total !== want.snapshot_total)
				diffs = {diffs, $sformatf(" snapshots %0d/%0d", got.snapshot_total,
					want.snapshot_total)};
			if (diffs != "")
				report({"result differs (got/expected):", diffs});
		endtask
	endclass

endpackage

### tb/pretrigger_snapshot_capture_test.sv
`timescale 1ns / 1ps
// Top of the pretrigger snapshot capture testbench: clock, reset, drivers and monitor.
// Depends on psc_pkg, psc_in_if, psc_out_if, psc_tb_pkg and the block itself.
module pretrigger_snapshot_capture_test;
	import psc_pkg::*;
	import psc_tb_pkg::*;

	// Input transactions per random phase; unknown opcodes are not counted.
	localparam int PHASE_ITEMS = 95;
	// Length of the long receiver hold-off that fills the block's output stages.
	localparam int HOLD_CYCLES = 300;
	// Bound on waiting for outstanding results, and the quiet time after them.
	localparam int DRAIN_LIMIT = 5000;
	localparam int TAIL_CYCLES = 10;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [THR_W-1:0] cfg_wr_data;

	psc_in_if  in_ch();
	psc_out_if out_ch();

	capture_scoreboard sb = new();

	// Percent of cycles in which the sender idles and the receiver stalls.
	int send_idle_pct = 0;
	int stall_pct     = 0;
	// Set by the main sequence; the receiver process turns it into a counted hold-off.
	bit hold_request  = 1'b0;
	// Counted input transactions sent so far.
	int issued        = 0;

	pretrigger_snapshot_capture #(
		.HIST_DEPTH(HIST_DEPTH),
		.SNAP_DEPTH(SNAP_DEPTH),
		.BLOCK_SIZE(BLOCK_SIZE)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_ch      (in_ch),
		.out_ch     (out_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Everything is driven on the rising edge, so both channels are stable at the falling
	// edge and hold the same values the block sees at the next rising edge. Sampling there
	// makes the handshake check free of any ordering within a time step. The input is noted
	// before the output is checked, so even a same-cycle result would find its expectation.
	always @(negedge clk) begin : monitor
		res_t got;
		if (arst_n === 1'b1) begin
			if (in_ch.valid && in_ch.ready)
				sb.note_input(in_ch.opcode, in_ch.sample_value, in_ch.back_distance,
					in_ch.snapshot_length);
			if (out_ch.valid && out_ch.ready) begin
				got.status         = out_ch.status;
				got.data_value     = out_ch.data_value;
				got.last           = out_ch.last;
				got.trigger_total  = out_ch.trigger_total;
				got.snapshot_total = out_ch.snapshot_total;
				sb.check_result(got);
			end
		end
	end

	// Receiver: stalls at random per cycle, or holds ready low for a counted stretch on
	// request so that the output register and the skid stage both fill and the input stalls.
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(99, 0) >= stall_pct);
			end
		end
	end

	// Hard stop; far beyond the slowest correct run.
	initial begin
		#5_000_000;
		$display("[pretrigger_snapshot_capture] ERROR");
		$finish;
	end

	// Random values at the width of each input field.
	function automatic logic signed [SMP_W-1:0] rnd_smp();
		return SMP_W'($urandom());
	endfunction

	function automatic logic [BACK_W-1:0] rnd_back();
		return BACK_W'($urandom());
	endfunction

	function automatic logic [LEN_W-1:0] rnd_len();
		return LEN_W'($urandom());
	endfunction

	// Offers one transaction and returns at the rising edge that accepts it. Valid stays high,
	// so a following transaction can go out with no gap.
	task automatic send_item(input logic [OPC_W-1:0] op, input logic signed [SMP_W-1:0] smp,
			input logic [BACK_W-1:0] back, input logic [LEN_W-1:0] len);
		bit taken;
		in_ch.valid           <= 1'b1;
		in_ch.opcode          <= op;
		in_ch.sample_value    <= smp;
		in_ch.back_distance   <= back;
		in_ch.snapshot_length <= len;
		do begin
			@(negedge clk);
			taken = in_ch.ready;
			@(posedge clk);
		end while (!taken);
	endtask

	// Sends one transaction, then idles the sender for a random number of cycles.
	task automatic issue(input logic [OPC_W-1:0] op, input logic signed [SMP_W-1:0] smp,
			input logic [BACK_W-1:0] back, input logic [LEN_W-1:0] len);
		send_item(op, smp, back, len);
		if (op <= OP_CLEAR)
			issued++;
		while ($urandom_range(99, 0) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Mostly quiet samples inside the threshold band, a few beyond it, some fully random.
	function automatic logic signed [SMP_W-1:0] pick_sample(input logic [THR_W-1:0] thr);
		int r;
		int mag;
		int t;
		t = int'(thr);
		r = $urandom_range(99, 0);
		if (r < 8)
			return rnd_smp();
		if (r < 13) begin
			// Only the most negative code exceeds the largest threshold.
			if (t >= 32767 || $urandom_range(7, 0) == 0)
				return 16'sh8000;
			mag = $urandom_range(32767, t + 1);
			return SMP_W'($urandom_range(1, 0) ? mag : -mag);
		end
		mag = $urandom_range(t, 0);
		return SMP_W'($urandom_range(1, 0) ? mag : -mag);
	endfunction

	// Drain lengths: mostly legal, some empty, some too long.
	function automatic logic [LEN_W-1:0] pick_length();
		int r;
		r = $urandom_range(99, 0);
		if (r < 10)
			return '0;
		if (r < 22)
			return LEN_W'($urandom_range(127, SNAP_DEPTH + 1));
		return LEN_W'($urandom_range(SNAP_DEPTH, 1));
	endfunction

	// Waits for every expected result, bounded, then lets the block go quiet.
	task automatic settle();
		int waited;
		waited = 0;
		in_ch.valid <= 1'b0;
		while (sb.pending_count() > 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// Only called while the block is idle.
	task automatic write_threshold(input logic [THR_W-1:0] value);
		cfg_wr_data <= value;
		cfg_wr_en   <= 1'b1;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		sb.threshold = value;
	endtask

	// Short directed run on the reset threshold of 2000.
	task automatic directed_items();
		// Cleared ring reads as zero; a distance of zero reaches the oldest entry.
		issue(OP_HISTORY, rnd_smp(), 8'd0, rnd_len());
		// Service with no capture latched.
		issue(OP_SERVICE, rnd_smp(), rnd_back(), rnd_len());
		// Drain with no snapshot ready is refused.
		issue(OP_SNAPSHOT, rnd_smp(), rnd_back(), 7'd1);
		issue(OP_UNKNOWN_HI, rnd_smp(), rnd_back(), rnd_len());
		// First block: values right at plus and minus the threshold do not trigger;
		// one just above it does, so the block end latches a capture.
		issue(OP_SAMPLE, 16'sd0, rnd_back(), rnd_len());
		issue(OP_SAMPLE, 16'sd2000, rnd_back(), rnd_len());
		issue(OP_SAMPLE, -16'sd2000, rnd_back(), rnd_len());
		issue(OP_SAMPLE, 16'sd1, rnd_back(), rnd_len());
		issue(OP_SAMPLE, -16'sd1, rnd_back(), rnd_len());
		issue(OP_SAMPLE, 16'sd300, rnd_back(), rnd_len());
		issue(OP_SAMPLE, -16'sd1999, rnd_back(), rnd_len());
		issue(OP_SAMPLE, 16'sd2001, rnd_back(), rnd_len());
		// Second block: full-scale hits while the capture is still pending are dropped.
		issue(OP_SAMPLE, 16'sh7FFF, rnd_back(), rnd_len());
		issue(OP_SAMPLE, 16'sh8000, rnd_back(), rnd_len());
		issue(OP_SAMPLE, -16'sd2001, rnd_back(), rnd_len());
		repeat (BLOCK_SIZE - 3)
			issue(OP_SAMPLE, 16'sd0, rnd_back(), rnd_len());
		// Capture copies a window that wraps round the ring; a second service finds the
		// snapshot still ready and does nothing.
		issue(OP_SERVICE, rnd_smp(), rnd_back(), rnd_len());
		issue(OP_SERVICE, rnd_smp(), rnd_back(), rnd_len());
		// One word too many is refused; the full length then drains everything.
		issue(OP_SNAPSHOT, rnd_smp(), rnd_back(), LEN_W'(SNAP_DEPTH + 1));
		issue(OP_SNAPSHOT, rnd_smp(), rnd_back(), LEN_W'(SNAP_DEPTH));
		issue(OP_HISTORY, rnd_smp(), 8'd255, rnd_len());
		issue(OP_CLEAR, rnd_smp(), rnd_back(), rnd_len());
	endtask

	// Random traffic built mostly from well-formed sequences: a run of samples that crosses
	// block boundaries, then a service and a drain, with reads, clears and noise mixed in.
	task automatic random_items(input int quota);
		int start;
		int r;
		int n;
		start = issued;
		while (issued - start < quota) begin
			r = $urandom_range(99, 0);
			if (r < 60) begin
				n = $urandom_range(20, 1);
				repeat (n)
					issue(OP_SAMPLE, pick_sample(sb.threshold), rnd_back(), rnd_len());
				if ($urandom_range(9, 0) < 7)
					issue(OP_SERVICE, rnd_smp(), rnd_back(), rnd_len());
				if ($urandom_range(9, 0) < 6)
					issue(OP_SNAPSHOT, rnd_smp(), rnd_back(), pick_length());
				if ($urandom_range(9, 0) < 2)
					issue(OP_HISTORY, rnd_smp(), rnd_back(), rnd_len());
			end else if (r < 75) begin
				repeat ($urandom_range(3, 1))
					issue(OP_HISTORY, rnd_smp(), rnd_back(), rnd_len());
			end else if (r < 85) begin
				issue(OP_SERVICE, rnd_smp(), rnd_back(), rnd_len());
			end else if (r < 94) begin
				issue(OP_SNAPSHOT, rnd_smp(), rnd_back(), rnd_len());
			end else if (r < 97) begin
				issue(OP_CLEAR, rnd_smp(), rnd_back(), rnd_len());
			end else begin
				issue(OPC_W'($urandom_range(OP_UNKNOWN_HI, OP_UNKNOWN_LO)), rnd_smp(),
					rnd_back(), rnd_len());
			end
		end
	endtask

	initial begin : main_sequence
		logic [THR_W-1:0] thr;
		arst_n                <= 1'b0;
		cfg_wr_en             <= 1'b0;
		cfg_wr_data           <= '0;
		in_ch.valid           <= 1'b0;
		in_ch.opcode          <= OP_SAMPLE;
		in_ch.sample_value    <= '0;
		in_ch.back_distance   <= '0;
		in_ch.snapshot_length <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_items();
		settle();

		// Each phase sets its own idling and a new threshold, the extremes among them.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
			0: begin
				send_idle_pct = 0;
				stall_pct     = 0;
				thr           = 15'd32767;
			end
			1: begin
				send_idle_pct = 55;
				stall_pct     = 0;
				thr           = 15'd0;
			end
			2: begin
				send_idle_pct = 0;
				stall_pct     = 55;
				thr           = THR_W'($urandom_range(32766, 1));
			end
			default: begin
				send_idle_pct = 32;
				stall_pct     = 32;
				thr           = THR_RESET;
			end
			endcase
			write_threshold(thr);
			// Back-to-back input against a receiver that holds off for a long time.
			if (phase == 2)
				hold_request = 1'b1;
			random_items(PHASE_ITEMS);
			settle();
		end

		if (sb.pending_count() > 0)
			sb.report($sformatf("%0d expected results never arrived", sb.pending_count()));
		if (sb.error_count == 0)
			$display("[pretrigger_snapshot_capture] OK");
		else
			$display("[pretrigger_snapshot_capture] ERROR");
		$finish;
	end

endmodule
